### rtl/rwhp_pkg.sv
package rwhp_pkg;

  // Tags as they appear in file order, first byte in the top bits.
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // Bytes of a fmt chunk body that carry fields we keep.
  localparam logic [31:0] FMT_CAPTURE_BYTES = 32'd16;
  // Bytes in a tag or size field.
  localparam logic [31:0] FIELD_BYTES       = 32'd4;

  localparam logic [15:0] FORMAT_PCM   = 16'd1;
  localparam logic [12:0] PCM16_WIDTH  = 13'd2;
  localparam logic [15:0] MONO_COUNT   = 16'd1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_RIFF    = 3'd1,
    ST_NO_WAVE    = 3'd2,
    ST_NO_CHUNK   = 3'd3,
    ST_BAD_FORMAT = 3'd4,
    ST_NOT_MONO   = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] channels;
    logic [31:0] rate_hz;
    logic [12:0] sample_bytes;
    logic [31:0] body_start;
    logic [31:0] body_size;
  } result_t;

endpackage

### rtl/rwhp_in_stage.sv
module rwhp_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rwhp_pkg::item_t in_item,
  input  logic            advance,
  output logic            item_valid,
  output rwhp_pkg::item_t item
);

  logic            valid_r;
  rwhp_pkg::item_t item_r;

  // The held word leaves on the same edge that a new one arrives.
  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

### rtl/rwhp_parser.sv
module rwhp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  rwhp_pkg::item_t   item,
  output logic              res_valid,
  output rwhp_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_RIFF  = 3'd0,
    PH_RSIZE = 3'd1,
    PH_WAVE  = 3'd2,
    PH_CID   = 3'd3,
    PH_CSIZE = 3'd4,
    PH_BODY  = 3'd5,
    PH_PAD   = 3'd6
  } phase_t;

  phase_t      phase_r,   phase_nxt;
  logic [31:0] pos_r,     pos_nxt;
  logic [31:0] cnt_r,     cnt_nxt;
  logic [31:0] tag_r,     tag_nxt;
  logic [31:0] len_r,     len_nxt;
  logic        have_fmt_r, have_fmt_nxt;
  logic        have_data_r, have_data_nxt;
  logic [15:0] fmt_code_r, fmt_code_nxt;
  logic [15:0] chan_r,    chan_nxt;
  logic [31:0] rate_r,    rate_nxt;
  logic [15:0] bits_r,    bits_nxt;
  logic [31:0] offset_r,  offset_nxt;
  logic [31:0] length_r,  length_nxt;
  logic        done_r,    done_nxt;

  logic             emit;
  rwhp_pkg::status_t status;
  logic [31:0]      k;
  logic [31:0]      lim;
  logic             is_fmt;
  logic [7:0]       b;

  assign b = item.data_byte;

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    tag_nxt       = tag_r;
    len_nxt       = len_r;
    have_fmt_nxt  = have_fmt_r;
    have_data_nxt = have_data_r;
    fmt_code_nxt  = fmt_code_r;
    chan_nxt      = chan_r;
    rate_nxt      = rate_r;
    bits_nxt      = bits_r;
    offset_nxt    = offset_r;
    length_nxt    = length_r;
    done_nxt      = done_r;
    emit          = 1'b0;
    status        = rwhp_pkg::ST_OK;
    k             = 32'd0;
    lim           = 32'd0;

    // A new file restarts the parser before its first byte is taken.
    if (item.first_byte) begin
      phase_nxt     = PH_RIFF;
      pos_nxt       = 32'd0;
      cnt_nxt       = 32'd0;
      tag_nxt       = 32'd0;
      len_nxt       = 32'd0;
      have_fmt_nxt  = 1'b0;
      have_data_nxt = 1'b0;
      fmt_code_nxt  = 16'd0;
      chan_nxt      = 16'd0;
      rate_nxt      = 32'd0;
      bits_nxt      = 16'd0;
      offset_nxt    = 32'd0;
      length_nxt    = 32'd0;
      done_nxt      = 1'b0;
    end

    is_fmt = (tag_nxt == rwhp_pkg::TAG_FMT);

    if (!done_nxt) begin
      pos_nxt = pos_nxt + 32'd1;
      unique case (phase_nxt)
        PH_RIFF, PH_WAVE: begin
          tag_nxt = {tag_nxt[23:0], b};
          cnt_nxt = cnt_nxt + 32'd1;
          if (cnt_nxt >= rwhp_pkg::FIELD_BYTES) begin
            cnt_nxt = 32'd0;
            if (phase_nxt == PH_RIFF) begin
              if (tag_nxt != rwhp_pkg::TAG_RIFF) begin
                emit   = 1'b1;
                status = rwhp_pkg::ST_NO_RIFF;
              end else begin
                phase_nxt = PH_RSIZE;
              end
            end else begin
              if (tag_nxt != rwhp_pkg::TAG_WAVE) begin
                emit   = 1'b1;
                status = rwhp_pkg::ST_NO_WAVE;
              end else begin
                phase_nxt = PH_CID;
              end
            end
            tag_nxt = 32'd0;
          end
        end
        PH_RSIZE: begin
          cnt_nxt = cnt_nxt + 32'd1;
          if (cnt_nxt >= rwhp_pkg::FIELD_BYTES) begin
            cnt_nxt   = 32'd0;
            phase_nxt = PH_WAVE;
          end
        end
        PH_CSIZE: begin
          len_nxt = len_nxt | ({24'd0, b} << {cnt_nxt[1:0], 3'b000});
          cnt_nxt = cnt_nxt + 32'd1;
          if (cnt_nxt >= rwhp_pkg::FIELD_BYTES) begin
            cnt_nxt = 32'd0;
            if (is_fmt) begin
              fmt_code_nxt = 16'd0;
              chan_nxt     = 16'd0;
              rate_nxt     = 32'd0;
              bits_nxt     = 16'd0;
              have_fmt_nxt = (len_nxt == 32'd0);
            end else if (tag_nxt == rwhp_pkg::TAG_DATA) begin
              offset_nxt    = pos_nxt;
              length_nxt    = len_nxt;
              have_data_nxt = 1'b1;
            end
            phase_nxt = (len_nxt == 32'd0) ? PH_CID : PH_BODY;
          end
        end
        PH_BODY: begin
          k = cnt_nxt;
          if (is_fmt && (k < rwhp_pkg::FMT_CAPTURE_BYTES)) begin
            case (k[3:0])
              4'd0:    fmt_code_nxt[7:0]  = fmt_code_nxt[7:0]  | b;
              4'd1:    fmt_code_nxt[15:8] = fmt_code_nxt[15:8] | b;
              4'd2:    chan_nxt[7:0]      = chan_nxt[7:0]      | b;
              4'd3:    chan_nxt[15:8]     = chan_nxt[15:8]     | b;
              4'd4:    rate_nxt[7:0]      = rate_nxt[7:0]      | b;
              4'd5:    rate_nxt[15:8]     = rate_nxt[15:8]     | b;
              4'd6:    rate_nxt[23:16]    = rate_nxt[23:16]    | b;
              4'd7:    rate_nxt[31:24]    = rate_nxt[31:24]    | b;
              4'd14:   bits_nxt[7:0]      = bits_nxt[7:0]      | b;
              4'd15:   bits_nxt[15:8]     = bits_nxt[15:8]     | b;
              default: ;
            endcase
          end
          cnt_nxt = k + 32'd1;
          lim = (len_nxt < rwhp_pkg::FMT_CAPTURE_BYTES) ? len_nxt
                                                         : rwhp_pkg::FMT_CAPTURE_BYTES;
          if (is_fmt && (cnt_nxt == lim)) begin
            have_fmt_nxt = 1'b1;
          end
          if (cnt_nxt == len_nxt) begin
            cnt_nxt   = 32'd0;
            phase_nxt = len_nxt[0] ? PH_PAD : PH_CID;
          end
        end
        PH_PAD: begin
          cnt_nxt   = 32'd0;
          phase_nxt = PH_CID;
        end
        default: begin
          // Chunk tag; the spare phase code also lands here.
          if (phase_nxt != PH_CID) begin
            phase_nxt = PH_CID;
            cnt_nxt   = 32'd0;
          end
          tag_nxt = {tag_nxt[23:0], b};
          cnt_nxt = cnt_nxt + 32'd1;
          if (cnt_nxt >= rwhp_pkg::FIELD_BYTES) begin
            cnt_nxt   = 32'd0;
            len_nxt   = 32'd0;
            phase_nxt = PH_CSIZE;
          end
        end
      endcase

      if (!emit && have_fmt_nxt && have_data_nxt) begin
        emit = 1'b1;
        if ((fmt_code_nxt != rwhp_pkg::FORMAT_PCM) ||
            (bits_nxt[15:3] != rwhp_pkg::PCM16_WIDTH)) begin
          status = rwhp_pkg::ST_BAD_FORMAT;
        end else if (chan_nxt != rwhp_pkg::MONO_COUNT) begin
          status = rwhp_pkg::ST_NOT_MONO;
        end else begin
          status = rwhp_pkg::ST_OK;
        end
      end

      if (!emit && item.end_of_file) begin
        emit = 1'b1;
        if (phase_nxt == PH_RIFF) begin
          status = rwhp_pkg::ST_NO_RIFF;
        end else if ((phase_nxt == PH_RSIZE) || (phase_nxt == PH_WAVE)) begin
          status = rwhp_pkg::ST_NO_WAVE;
        end else begin
          status = rwhp_pkg::ST_NO_CHUNK;
        end
      end

      if (emit) begin
        done_nxt = 1'b1;
      end
    end
  end

  assign res_valid        = emit;
  assign res.status       = status;
  assign res.channels     = chan_nxt;
  assign res.rate_hz      = rate_nxt;
  assign res.sample_bytes = bits_nxt[15:3];
  assign res.body_start   = offset_nxt;
  assign res.body_size    = length_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RIFF;
      pos_r       <= 32'd0;
      cnt_r       <= 32'd0;
      tag_r       <= 32'd0;
      len_r       <= 32'd0;
      have_fmt_r  <= 1'b0;
      have_data_r <= 1'b0;
      fmt_code_r  <= 16'd0;
      chan_r      <= 16'd0;
      rate_r      <= 32'd0;
      bits_r      <= 16'd0;
      offset_r    <= 32'd0;
      length_r    <= 32'd0;
      done_r      <= 1'b0;
    end else if (take) begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      tag_r       <= tag_nxt;
      len_r       <= len_nxt;
      have_fmt_r  <= have_fmt_nxt;
      have_data_r <= have_data_nxt;
      fmt_code_r  <= fmt_code_nxt;
      chan_r      <= chan_nxt;
      rate_r      <= rate_nxt;
      bits_r      <= bits_nxt;
      offset_r    <= offset_nxt;
      length_r    <= length_nxt;
      done_r      <= done_nxt;
    end
  end

endmodule

### rtl/rwhp_out_stage.sv
module rwhp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  rwhp_pkg::result_t res,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output rwhp_pkg::result_t out_res
);

  logic              valid_r;
  rwhp_pkg::result_t res_r;

  // A new result may replace the one being taken in the same cycle.
  assign room      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

### rtl/riff_wave_header_parser_core.sv
// Channel  Direction  Handshake               Word
// in_      input      in_valid / in_ready     data_byte, first_byte, end_of_file
// out_     output     out_valid / out_ready   status, header fields; at most one per file
//
// One byte is parsed per cycle unless held; a result is registered as its byte is parsed.
// The byte rate is set by the single parse step between the input and result registers.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to the
// RIFF tag. While the result register is full and out_ready is low the parser holds,
// and in_ready drops once the input register is also full.
module riff_wave_header_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_channels,
  output logic [31:0] out_rate_hz,
  output logic [12:0] out_sample_bytes,
  output logic [31:0] out_body_start,
  output logic [31:0] out_body_size
);

  rwhp_pkg::item_t   in_item;
  rwhp_pkg::item_t   item;
  rwhp_pkg::result_t res;
  rwhp_pkg::result_t out_res;
  logic              item_valid;
  logic              room;
  logic              take;
  logic              res_valid;

  assign in_item.data_byte   = in_data_byte;
  assign in_item.first_byte  = in_first_byte;
  assign in_item.end_of_file = in_end_of_file;

  assign take = item_valid && room;

  rwhp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (take),
    .item_valid (item_valid),
    .item       (item)
  );

  rwhp_parser u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  rwhp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && res_valid),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status       = out_res.status;
  assign out_channels     = out_res.channels;
  assign out_rate_hz      = out_res.rate_hz;
  assign out_sample_bytes = out_res.sample_bytes;
  assign out_body_start   = out_res.body_start;
  assign out_body_size    = out_res.body_size;

endmodule

### verif/riff_wave_header_parser_core_tb.sv
module riff_wave_header_parser_core_tb;

  localparam int RANDOM_BYTES = 1825;

  typedef enum logic [3:0] {
    PS_RIFF_TAG,
    PS_RIFF_SIZE,
    PS_WAVE_TAG,
    PS_CHUNK_TAG,
    PS_CHUNK_SIZE,
    PS_BODY,
    PS_PAD
  } parse_phase_t;

  typedef struct {
    logic [7:0]        value;
    bit                first;
    bit                eof;
    bit                typed;
    rwhp_pkg::status_t status;
  } probe_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_first_byte;
  logic        in_end_of_file;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [15:0] out_channels;
  logic [31:0] out_rate_hz;
  logic [12:0] out_sample_bytes;
  logic [31:0] out_body_start;
  logic [31:0] out_body_size;

  riff_wave_header_parser_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_first_byte    (in_first_byte),
    .in_end_of_file   (in_end_of_file),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_channels     (out_channels),
    .out_rate_hz      (out_rate_hz),
    .out_sample_bytes (out_sample_bytes),
    .out_body_start   (out_body_start),
    .out_body_size    (out_body_size)
  );

  // Short files whose status can be read straight off the header rules.
  probe_t probe_rows [25] = '{
    '{8'h00, 1'b1, 1'b1, 1'b1, rwhp_pkg::ST_NO_RIFF},
    '{8'h52, 1'b1, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'h49, 1'b0, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'h52, 1'b1, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'h49, 1'b0, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'h46, 1'b0, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'h58, 1'b0, 1'b0, 1'b1, rwhp_pkg::ST_NO_RIFF},
    '{8'hFF, 1'b0, 1'b1, 1'b0, rwhp_pkg::ST_OK},
    '{8'h52, 1'b1, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'h49, 1'b0, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'h46, 1'b0, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'h46, 1'b0, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b1, 1'b1, rwhp_pkg::ST_NO_WAVE},
    '{8'h52, 1'b1, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'h49, 1'b0, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'h46, 1'b0, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'h46, 1'b0, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'h80, 1'b0, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'h7F, 1'b0, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'h57, 1'b0, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'h41, 1'b0, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'h56, 1'b0, 1'b0, 1'b0, rwhp_pkg::ST_OK},
    '{8'h46, 1'b0, 1'b0, 1'b1, rwhp_pkg::ST_NO_WAVE}
  };

  // Parser state mirrored by the predictor.
  parse_phase_t pr_phase;
  logic [31:0]  pr_position;
  logic [31:0]  pr_count;
  logic [31:0]  pr_tag;
  logic [31:0]  pr_length;
  bit           pr_have_fmt;
  bit           pr_have_data;
  logic [15:0]  pr_format;
  logic [15:0]  pr_channels;
  logic [31:0]  pr_rate;
  logic [15:0]  pr_bits;
  logic [31:0]  pr_body_offset;
  logic [31:0]  pr_body_length;
  bit           pr_done;

  rwhp_pkg::result_t pending_headers[$];
  logic [7:0]  file_bytes[$];
  bit          file_ends;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_cycles;
  int          mismatches;
  int          bytes_sent;
  int          bytes_parsed;
  int          files_sent;
  int          headers_predicted;
  int          headers_checked;
  int          status_seen [8];

  task automatic clear_parser();
    pr_phase       = PS_RIFF_TAG;
    pr_position    = '0;
    pr_count       = '0;
    pr_tag         = '0;
    pr_length      = '0;
    pr_have_fmt    = 1'b0;
    pr_have_data   = 1'b0;
    pr_format      = '0;
    pr_channels    = '0;
    pr_rate        = '0;
    pr_bits        = '0;
    pr_body_offset = '0;
    pr_body_length = '0;
    pr_done        = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] value, input bit first, input bit eof,
                            output bit emit, output rwhp_pkg::result_t hdr);
    logic [31:0]       pos;
    logic [31:0]       k;
    logic [31:0]       lim;
    rwhp_pkg::status_t st;
    emit = 1'b0;
    hdr  = '0;
    st   = rwhp_pkg::ST_OK;
    if (first)
      clear_parser();
    if (pr_done)
      return;
    bytes_parsed++;
    pos = pr_position;
    pr_position = pos + 1;
    case (pr_phase)
      PS_RIFF_TAG, PS_WAVE_TAG: begin
        pr_tag = {pr_tag[23:0], value};
        pr_count++;
        if (pr_count >= rwhp_pkg::FIELD_BYTES) begin
          pr_count = '0;
          if (pr_phase == PS_RIFF_TAG) begin
            if (pr_tag != rwhp_pkg::TAG_RIFF) begin
              emit = 1'b1;
              st   = rwhp_pkg::ST_NO_RIFF;
            end else begin
              pr_phase = PS_RIFF_SIZE;
            end
          end else begin
            if (pr_tag != rwhp_pkg::TAG_WAVE) begin
              emit = 1'b1;
              st   = rwhp_pkg::ST_NO_WAVE;
            end else begin
              pr_phase = PS_CHUNK_TAG;
            end
          end
          pr_tag = '0;
        end
      end
      PS_RIFF_SIZE: begin
        pr_count++;
        if (pr_count >= rwhp_pkg::FIELD_BYTES) begin
          pr_count = '0;
          pr_phase = PS_WAVE_TAG;
        end
      end
      PS_CHUNK_SIZE: begin
        pr_length[8 * pr_count[1:0] +: 8] = value;
        pr_count++;
        if (pr_count >= rwhp_pkg::FIELD_BYTES) begin
          pr_count = '0;
          if (pr_tag == rwhp_pkg::TAG_FMT) begin
            pr_format   = '0;
            pr_channels = '0;
            pr_rate     = '0;
            pr_bits     = '0;
            pr_have_fmt = (pr_length == 0);
          end else if (pr_tag == rwhp_pkg::TAG_DATA) begin
            pr_body_offset = pos + 1;
            pr_body_length = pr_length;
            pr_have_data   = 1'b1;
          end
          pr_phase = (pr_length == 0) ? PS_CHUNK_TAG : PS_BODY;
        end
      end
      PS_BODY: begin
        k = pr_count;
        if (pr_tag == rwhp_pkg::TAG_FMT && k < rwhp_pkg::FMT_CAPTURE_BYTES) begin
          if (k < 2)
            pr_format[8 * k[0] +: 8] = value;
          else if (k < 4)
            pr_channels[8 * k[0] +: 8] = value;
          else if (k < 8)
            pr_rate[8 * k[1:0] +: 8] = value;
          else if (k >= 14)
            pr_bits[8 * k[0] +: 8] = value;
        end
        pr_count = k + 1;
        lim = (pr_length < rwhp_pkg::FMT_CAPTURE_BYTES) ? pr_length
                                                        : rwhp_pkg::FMT_CAPTURE_BYTES;
        if (pr_tag == rwhp_pkg::TAG_FMT && pr_count == lim)
          pr_have_fmt = 1'b1;
        if (pr_count == pr_length) begin
          pr_count = '0;
          pr_phase = pr_length[0] ? PS_PAD : PS_CHUNK_TAG;
        end
      end
      PS_PAD: begin
        pr_count = '0;
        pr_phase = PS_CHUNK_TAG;
      end
      default: begin
        pr_tag = {pr_tag[23:0], value};
        pr_count++;
        if (pr_count >= rwhp_pkg::FIELD_BYTES) begin
          pr_count  = '0;
          pr_length = '0;
          pr_phase  = PS_CHUNK_SIZE;
        end
      end
    endcase

    if (!emit && pr_have_fmt && pr_have_data) begin
      emit = 1'b1;
      if (pr_format != rwhp_pkg::FORMAT_PCM || pr_bits[15:3] != rwhp_pkg::PCM16_WIDTH)
        st = rwhp_pkg::ST_BAD_FORMAT;
      else if (pr_channels != rwhp_pkg::MONO_COUNT)
        st = rwhp_pkg::ST_NOT_MONO;
      else
        st = rwhp_pkg::ST_OK;
    end
    if (!emit && eof) begin
      emit = 1'b1;
      if (pr_phase == PS_RIFF_TAG)
        st = rwhp_pkg::ST_NO_RIFF;
      else if (pr_phase == PS_RIFF_SIZE || pr_phase == PS_WAVE_TAG)
        st = rwhp_pkg::ST_NO_WAVE;
      else
        st = rwhp_pkg::ST_NO_CHUNK;
    end
    if (emit) begin
      pr_done          = 1'b1;
      hdr.status       = st;
      hdr.channels     = pr_channels;
      hdr.rate_hz      = pr_rate;
      hdr.sample_bytes = pr_bits[15:3];
      hdr.body_start   = pr_body_offset;
      hdr.body_size    = pr_body_length;
    end
  endtask

  // Offers one word, waits for it to be taken, then updates the prediction.
  task automatic send_word(input logic [7:0] value, input bit first, input bit eof,
                           input bit use_prediction);
    bit                emit;
    rwhp_pkg::result_t hdr;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= value;
    in_first_byte  <= first;
    in_end_of_file <= eof;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    bytes_sent++;
    parse_byte(value, first, eof, emit, hdr);
    if (emit && use_prediction) begin
      pending_headers.push_back(hdr);
      headers_predicted++;
    end
  endtask

  task automatic push_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++)
      file_bytes.push_back(v[8 * i +: 8]);
  endtask

  task automatic push_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--)
      file_bytes.push_back(t[8 * i +: 8]);
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++)
      file_bytes.push_back(8'($urandom));
  endtask

  task automatic add_fmt_chunk();
    logic [31:0]  size;
    logic [15:0]  code;
    logic [15:0]  chans;
    logic [15:0]  bits;
    logic [127:0] body;
    int           pick;
    pick = $urandom_range(99);
    if (pick < 60)
      size = 16;
    else if (pick < 75)
      size = 18;
    else if (pick < 90)
      size = $urandom_range(0, 15);
    else
      size = 17;
    code  = ($urandom_range(99) < 75) ? rwhp_pkg::FORMAT_PCM : 16'($urandom);
    pick  = $urandom_range(99);
    chans = (pick < 70) ? rwhp_pkg::MONO_COUNT :
            (pick < 85) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    pick  = $urandom_range(99);
    bits  = (pick < 70) ? 16'd16 : (pick < 80) ? 16'($urandom_range(8, 23)) : 16'($urandom);
    body  = {bits, 16'($urandom), 32'($urandom), 32'($urandom), chans, code};
    push_tag(rwhp_pkg::TAG_FMT);
    push_le(size, 4);
    for (int i = 0; i < size; i++)
      file_bytes.push_back((i < 16) ? body[8 * i +: 8] : 8'($urandom));
    if (size[0])
      push_random(1);
  endtask

  // A data chunk with a huge size leaves no room for anything after it.
  task automatic add_data_chunk(output bit open_ended);
    logic [31:0] size;
    open_ended = ($urandom_range(99) < 25);
    size = open_ended ? 32'($urandom) : 32'($urandom_range(0, 24));
    push_tag(rwhp_pkg::TAG_DATA);
    push_le(size, 4);
    if (!open_ended)
      push_random(size + size[0]);
  endtask

  task automatic add_other_chunk();
    logic [31:0] size;
    int          pick;
    pick = $urandom_range(2);
    push_tag((pick == 0) ? 32'h4C49_5354 : (pick == 1) ? 32'h6661_6374 : 32'($urandom));
    size = $urandom_range(0, 9);
    push_le(size, 4);
    push_random(size + size[0]);
  endtask

  task automatic make_file();
    int kind;
    int chunks;
    int pick;
    bit open_end;
    file_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 8) begin
      push_random($urandom_range(1, 12));
    end else if (kind < 14) begin
      push_tag(rwhp_pkg::TAG_RIFF ^ (32'd1 << $urandom_range(31)));
      push_random($urandom_range(0, 6));
    end else if (kind < 22) begin
      push_tag(rwhp_pkg::TAG_RIFF);
      push_le($urandom, 4);
      push_tag(rwhp_pkg::TAG_WAVE ^ (32'd1 << $urandom_range(31)));
      push_random($urandom_range(0, 6));
    end else begin
      push_tag(rwhp_pkg::TAG_RIFF);
      push_le($urandom, 4);
      push_tag(rwhp_pkg::TAG_WAVE);
      chunks = $urandom_range(1, 5);
      for (int c = 0; c < chunks; c++) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          add_fmt_chunk();
        end else if (pick < 75) begin
          add_data_chunk(open_end);
          if (open_end)
            break;
        end else begin
          add_other_chunk();
        end
      end
    end
    // Some files are cut short, and a few run straight into the next one.
    pick = $urandom_range(99);
    if (pick < 8 && file_bytes.size() > 1)
      while (file_bytes.size() > 1 && $urandom_range(3) != 0)
        void'(file_bytes.pop_back());
    file_ends = (pick < 92);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++)
      send_word(file_bytes[i], i == 0, file_ends && i == file_bytes.size() - 1, 1'b1);
    files_sent++;
  endtask

  function automatic void compare_field(input string label, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: checks each header word taken and decides out_ready for the next cycle.
  initial begin
    rwhp_pkg::result_t want;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_headers.size() == 0) begin
          $display("%0t: unexpected header word, expected none, got status %0d", $time,
                   out_status);
          mismatches++;
        end else begin
          want = pending_headers.pop_front();
          headers_checked++;
          status_seen[want.status]++;
          compare_field("status", 32'(want.status), 32'(out_status));
          compare_field("channels", 32'(want.channels), 32'(out_channels));
          compare_field("rate_hz", want.rate_hz, out_rate_hz);
          compare_field("sample_bytes", 32'(want.sample_bytes), 32'(out_sample_bytes));
          compare_field("body_start", want.body_start, out_body_start);
          compare_field("body_size", want.body_size, out_body_size);
        end
      end
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int send_mix [4];
    int recv_mix [4];
    int target;
    send_mix = '{0, 79, 0, 27};
    recv_mix = '{0, 0, 79, 27};
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data_byte   = '0;
    in_first_byte  = 1'b0;
    in_end_of_file = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    clear_parser();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probe_rows[i]) begin
      if (probe_rows[i].typed)
        pending_headers.push_back(rwhp_pkg::result_t'{probe_rows[i].status, 16'd0, 32'd0,
                                                      13'd0, 32'd0, 32'd0});
      send_word(probe_rows[i].value, probe_rows[i].first, probe_rows[i].eof,
                !probe_rows[i].typed);
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_mix[p];
      recv_stall_pct = recv_mix[p];
      // Hold the result side off long enough for the block to back up its input.
      if (p == 0)
        hold_cycles = 150;
      target = $size(probe_rows) + (p + 1) * RANDOM_BYTES / 4;
      while (bytes_sent < target) begin
        make_file();
        send_file();
      end
    end
    in_valid <= 1'b0;

    while (pending_headers.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes (%0d parsed) in %0d random files plus a directed set.",
             bytes_sent, bytes_parsed, files_sent);
    $display("Headers: %0d predicted, %0d checked.", headers_predicted, headers_checked);
    $display("Status mix: ok %0d, no RIFF %0d, no WAVE %0d, no chunk %0d, %0s %0d, %0s %0d",
             status_seen[rwhp_pkg::ST_OK], status_seen[rwhp_pkg::ST_NO_RIFF],
             status_seen[rwhp_pkg::ST_NO_WAVE], status_seen[rwhp_pkg::ST_NO_CHUNK],
             "bad format", status_seen[rwhp_pkg::ST_BAD_FORMAT],
             "not mono", status_seen[rwhp_pkg::ST_NOT_MONO]);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #(12 * 500000);
    $display("Timed out with %0d header words outstanding.", pending_headers.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
